### design/twce_pkg.sv
// ----------------------------------------------------------------------------
// twce_pkg
// Shared widths, action codes, register indexes and payload types of the
// text-window cell engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package twce_pkg;

   localparam int ACTION_W   = 3;
   localparam int CHAR_W     = 8;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int CNT_W      = 5;
   localparam int COLOR_W    = 4;
   localparam int CELL_W     = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 7;

   localparam int MAX_COLS_DEFAULT = 80;
   localparam int MAX_ROWS_DEFAULT = 25;
   localparam int COLS_RESET       = 80;
   localparam int ROWS_RESET       = 25;

   localparam logic [COLOR_W-1:0] FG_RESET = 4'hf;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

   localparam logic [ACTION_W-1:0] ACT_PUT     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CLR_ALL = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CLR_ROW = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SCROLL  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SET_CUR = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_READ    = 3'd5;

   localparam logic [CSR_ADDR_W-1:0] REG_COLS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ROWS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_FG   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BG   = 2'd3;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHAR_W-1:0]   char_code;
      logic [ROW_W-1:0]    row_sel;
      logic [COL_W-1:0]    col_sel;
      logic [CNT_W-1:0]    scroll_count;
   } req_payload_type;

   typedef struct packed {
      logic [COL_W-1:0]   cursor_col;
      logic [ROW_W-1:0]   cursor_row;
      logic [CHAR_W-1:0]  cell_char;
      logic [COLOR_W-1:0] cell_fg;
      logic [COLOR_W-1:0] cell_bg;
      logic [CHAR_W-1:0]  shown_char;
   } rsp_payload_type;

endpackage

### design/twce_if.sv
// ----------------------------------------------------------------------------
// twce_if
// Valid/ready channels of the text-window cell engine: request and response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface twce_req_if;
   import twce_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface twce_rsp_if;
   import twce_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/text_window_char_engine.sv
// ----------------------------------------------------------------------------
// text_window_char_engine
// Character/colour cell store with cursor, wrap, tab, newline and scroll.
// Put char without scroll, set cursor and no-op finish in the execute state; read cell
// adds a read state, a tab straddling cells a second write; requests wait while busy.
// Clear all walks cols*rows cells, clear row cols cells, scroll and a put off the
// bottom row cols*rows cells (copy then blank), one cell per cycle on the write port.
// Reset clears cursor, registers and handshake state; the store is not swept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_window_char_engine #(
   parameter int MAX_COLS = twce_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = twce_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   twce_req_if.sink                         req,
   twce_rsp_if.source                       rsp,
   input  logic                             csr_we,
   input  logic [twce_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [twce_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import twce_pkg::*;

   localparam int DEPTH    = MAX_COLS * MAX_ROWS;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW       = AW + 1;
   localparam int RST_COLS = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;
   localparam int RST_ROWS = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_TAB2  = 3'd2;
   localparam logic [2:0] S_COPY  = 3'd3;
   localparam logic [2:0] S_BLANK = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   function automatic logic [COL_W-1:0] clamp_cols(input logic [COL_W-1:0] v);
      logic [COL_W-1:0] r;
      r = v;
      if (v == '0) r = COL_W'(1);
      else if (int'(v) > MAX_COLS) r = COL_W'(MAX_COLS);
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] clamp_rows(input logic [ROW_W-1:0] v);
      logic [ROW_W-1:0] r;
      r = v;
      if (v == '0) r = ROW_W'(1);
      else if (int'(v) > MAX_ROWS) r = ROW_W'(MAX_ROWS);
      return r;
   endfunction

   logic [CELL_W-1:0] cell_mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_wa, mem_ra;
   logic [CELL_W-1:0] mem_wd;

   logic [2:0]         state_ff, state_in;
   req_payload_type    item_ff;
   logic [COL_W-1:0]   cols_ff, cols_in;
   logic [ROW_W-1:0]   rows_ff, rows_in;
   logic [IW-1:0]      total_ff, total_in;
   logic [COLOR_W-1:0] fg_ff, fg_in, bg_ff, bg_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [IW-1:0]      ptr_ff, ptr_in, end_ff, end_in, src_ff, src_in;
   logic               scr_pend_ff, scr_pend_in;
   logic               copy_vld_ff, copy_vld_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;
   logic [CELL_W-1:0]  res_cell_ff, res_cell_in;
   logic               res_read_ff, res_read_in;

   logic               req_xfer, out_free;
   logic [CELL_W-1:0]  blank;
   logic [11:0]        row_prod, sel_prod, n_prod, size_prod;
   logic [IW-1:0]      cur_idx, sel_idx;
   logic [ROW_W-1:0]   row_cl, n_cl;
   logic [COL_W-1:0]   col_cl;
   logic [7:0]         col_step;
   logic [5:0]         row_step, row_w;
   logic               col_wrap, put_scroll, tab2;
   logic [COL_W-1:0]   put_col;
   logic [ROW_W-1:0]   put_row;
   logic               fin, fin_read, load;
   logic [CELL_W-1:0]  fin_cell, ld_cell;
   logic               ld_read;

   assign req.ready = (state_ff == S_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;
   assign blank     = {bg_ff, fg_ff, 8'h00};

   // cell addresses: cursor, clamped selection, scroll offset
   assign row_prod = 12'(cur_row_ff) * 12'(cols_ff);
   assign cur_idx  = IW'(row_prod) + IW'(cur_col_ff);
   assign row_cl   = (item_ff.row_sel >= rows_ff) ? rows_ff - ROW_W'(1) : item_ff.row_sel;
   assign col_cl   = (item_ff.col_sel >= cols_ff) ? cols_ff - COL_W'(1) : item_ff.col_sel;
   assign sel_prod = 12'(row_cl) * 12'(cols_ff);
   assign sel_idx  = IW'(sel_prod) + IW'(col_cl);
   assign n_cl     = (item_ff.scroll_count > rows_ff) ? rows_ff : item_ff.scroll_count;
   assign n_prod   = 12'(n_cl) * 12'(cols_ff);

   // cursor movement for a put
   always_comb begin
      if (item_ff.char_code == CH_NEWLINE) begin
         col_step = 8'd0;
         row_step = 6'(cur_row_ff) + 6'd1;
      end else if (item_ff.char_code == CH_TAB) begin
         col_step = 8'(cur_col_ff) + 8'd2;
         row_step = 6'(cur_row_ff);
      end else begin
         col_step = 8'(cur_col_ff) + 8'd1;
         row_step = 6'(cur_row_ff);
      end
      col_wrap   = (col_step >= 8'(cols_ff));
      row_w      = col_wrap ? row_step + 6'd1 : row_step;
      put_scroll = (row_w >= 6'(rows_ff));
      put_col    = (col_wrap || put_scroll) ? '0 : col_step[COL_W-1:0];
      put_row    = put_scroll ? rows_ff - ROW_W'(1) : row_w[ROW_W-1:0];
      tab2       = (item_ff.char_code == CH_TAB) && ((cur_idx + IW'(1)) < total_ff);
   end

   always_comb begin
      state_in    = state_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      ptr_in      = ptr_ff;
      end_in      = end_ff;
      src_in      = src_ff;
      scr_pend_in = scr_pend_ff;
      copy_vld_in = 1'b0;
      mem_we      = 1'b0;
      mem_wa      = ptr_ff[AW-1:0];
      mem_wd      = blank;
      mem_re      = 1'b0;
      mem_ra      = src_ff[AW-1:0];
      fin         = 1'b0;
      fin_cell    = '0;
      fin_read    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (item_ff.action)
               ACT_PUT: begin
                  cur_col_in = put_col;
                  cur_row_in = put_row;
                  if (item_ff.char_code != CH_NEWLINE) begin
                     mem_we = 1'b1;
                     mem_wa = cur_idx[AW-1:0];
                     mem_wd = (item_ff.char_code == CH_TAB) ? blank
                                                            : {bg_ff, fg_ff, item_ff.char_code};
                  end
                  if (tab2) begin
                     ptr_in      = cur_idx + IW'(1);
                     scr_pend_in = put_scroll;
                     state_in    = S_TAB2;
                  end else if (put_scroll) begin
                     ptr_in   = '0;
                     src_in   = IW'(cols_ff);
                     state_in = S_COPY;
                  end else begin
                     fin = 1'b1;
                  end
               end
               ACT_CLR_ALL: begin
                  ptr_in   = '0;
                  end_in   = total_ff;
                  state_in = S_BLANK;
               end
               ACT_CLR_ROW: begin
                  if (item_ff.row_sel < rows_ff) begin
                     ptr_in   = IW'(sel_prod);
                     end_in   = IW'(sel_prod) + IW'(cols_ff);
                     state_in = S_BLANK;
                  end else begin
                     fin = 1'b1;
                  end
               end
               ACT_SCROLL: begin
                  if (n_cl != '0) begin
                     ptr_in   = '0;
                     src_in   = IW'(n_prod);
                     state_in = S_COPY;
                  end else begin
                     fin = 1'b1;
                  end
               end
               ACT_SET_CUR: begin
                  cur_col_in = col_cl;
                  cur_row_in = row_cl;
                  fin        = 1'b1;
               end
               ACT_READ: begin
                  mem_re   = 1'b1;
                  mem_ra   = sel_idx[AW-1:0];
                  state_in = S_READ;
               end
               default: fin = 1'b1;
            endcase
         end
         S_TAB2: begin
            mem_we = 1'b1;
            if (scr_pend_ff) begin
               ptr_in   = '0;
               src_in   = IW'(cols_ff);
               state_in = S_COPY;
            end else begin
               fin = 1'b1;
            end
         end
         S_COPY: begin
            // source always runs ahead of destination, so one pass in order is safe
            if (src_ff != total_ff) begin
               mem_re      = 1'b1;
               src_in      = src_ff + IW'(1);
               copy_vld_in = 1'b1;
            end
            if (copy_vld_ff) begin
               mem_we = 1'b1;
               mem_wd = rd_data_ff;
               ptr_in = ptr_ff + IW'(1);
            end
            if ((src_ff == total_ff) && !copy_vld_ff) begin
               end_in   = total_ff;
               state_in = S_BLANK;
            end
         end
         S_BLANK: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + IW'(1);
            if ((ptr_ff + IW'(1)) == end_ff) fin = 1'b1;
         end
         S_READ: begin
            fin      = 1'b1;
            fin_read = 1'b1;
            fin_cell = rd_data_ff;
         end
         S_RESP: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (fin) state_in = out_free ? S_IDLE : S_RESP;
   end

   // result register; a result that cannot leave yet waits in S_RESP
   always_comb begin
      res_cell_in = fin ? fin_cell : res_cell_ff;
      res_read_in = fin ? fin_read : res_read_ff;
      ld_cell     = fin ? fin_cell : res_cell_ff;
      ld_read     = fin ? fin_read : res_read_ff;
      load        = out_free && (fin || (state_ff == S_RESP));

      rsp_data_in            = rsp_data_ff;
      if (load) begin
         rsp_data_in.cursor_col = cur_col_in;
         rsp_data_in.cursor_row = cur_row_in;
         rsp_data_in.cell_char  = ld_read ? ld_cell[7:0] : '0;
         rsp_data_in.cell_fg    = ld_read ? ld_cell[11:8] : '0;
         rsp_data_in.cell_bg    = ld_read ? ld_cell[15:12] : '0;
         rsp_data_in.shown_char = !ld_read ? '0 :
                                  (ld_cell[7:0] == 8'd0) ? CH_SPACE : ld_cell[7:0];
      end
      rsp_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   // configuration writes, to be made only while idle; the block itself does not enforce this
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      fg_in   = fg_ff;
      bg_in   = bg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_COLS: cols_in = clamp_cols(csr_wdata);
            REG_ROWS: rows_in = clamp_rows(csr_wdata[ROW_W-1:0]);
            REG_FG:   fg_in   = csr_wdata[COLOR_W-1:0];
            REG_BG:   bg_in   = csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
      size_prod = 12'(cols_in) * 12'(rows_in);
      total_in  = IW'(size_prod);
   end

   always_ff @(posedge clock) begin
      if (mem_we) cell_mem[mem_wa] <= mem_wd;
      if (mem_re) rd_data_ff <= cell_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (req_xfer) item_ff <= req.payload;
      ptr_in_reg: begin
         ptr_ff      <= ptr_in;
         end_ff      <= end_in;
         src_ff      <= src_in;
         scr_pend_ff <= scr_pend_in;
         rsp_data_ff <= rsp_data_in;
         res_cell_ff <= res_cell_in;
         res_read_ff <= res_read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cols_ff      <= COL_W'(RST_COLS);
         rows_ff      <= ROW_W'(RST_ROWS);
         total_ff     <= IW'(RST_COLS * RST_ROWS);
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         copy_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         total_ff     <= total_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         copy_vld_ff  <= copy_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && ((csr_addr == REG_COLS) || (csr_addr == REG_ROWS))) begin
            cur_col_ff <= (cur_col_ff >= cols_in) ? cols_in - COL_W'(1) : cur_col_ff;
            cur_row_ff <= (cur_row_ff >= rows_in) ? rows_in - ROW_W'(1) : cur_row_ff;
         end else begin
            cur_col_ff <= cur_col_in;
            cur_row_ff <= cur_row_in;
         end
      end
   end

endmodule

### design/twce_checker.sv
// ----------------------------------------------------------------------------
// twce_checker
// Port-level checks of the text-window cell engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twce_checker #(
   parameter int MAX_COLS = twce_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = twce_pkg::MAX_ROWS_DEFAULT
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input twce_pkg::rsp_payload_type rsp_payload
);
   import twce_pkg::*;

   // a finished result stays valid until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_rst_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // one item at a time: never two request transfers in a row
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(req_valid && req_ready))
      else $error("request taken while previous item still in work");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_payload.cursor_col) < MAX_COLS) &&
                    (int'(rsp_payload.cursor_row) < MAX_ROWS))
      else $error("cursor outside the store");

   // shown character follows the cell character, blank cells show as space, or all cell fields are zero
   a_shown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.cell_char != 8'd0) &&
                     (rsp_payload.shown_char == rsp_payload.cell_char)) ||
                    ((rsp_payload.cell_char == 8'd0) &&
                     (rsp_payload.shown_char == CH_SPACE)) ||
                    ((rsp_payload.cell_char == 8'd0) && (rsp_payload.shown_char == 8'd0) &&
                     (rsp_payload.cell_fg == 4'd0) && (rsp_payload.cell_bg == 4'd0)))
      else $error("shown character inconsistent with cell");

endmodule

bind text_window_char_engine twce_checker #(
   .MAX_COLS (MAX_COLS),
   .MAX_ROWS (MAX_ROWS)
) u_twce_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

### bench/text_window_char_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_window_char_engine_test
// Self-checking bench for the text-window cell engine. A scoreboard keeps its
// own copy of the cell store, cursor and window registers. It predicts the
// report of every request transfer and checks each response transfer against
// the oldest prediction. A directed opening is followed by random phases over
// several window sizes and colours. Both handshakes idle at random.
// ----------------------------------------------------------------------------

module text_window_char_engine_test;
   import twce_pkg::*;

   localparam int STORE_CELLS = MAX_COLS_DEFAULT * MAX_ROWS_DEFAULT;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 70;

   // actions the block treats as no-ops
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

   class char_window_scoreboard;
      logic [CELL_W-1:0]  cells [STORE_CELLS];
      int unsigned        cols_reg;
      int unsigned        rows_reg;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      int unsigned        cur_col;
      int unsigned        cur_row;
      rsp_payload_type    due_reports [$];
      int                 errors;

      function new();
         cols_reg = COLS_RESET;
         rows_reg = ROWS_RESET;
         fg       = FG_RESET;
         bg       = BG_RESET;
         cur_col  = 0;
         cur_row  = 0;
         errors   = 0;
         foreach (cells[i]) cells[i] = '0;
      endfunction

      function int unsigned width_now();
         if (cols_reg < 1) return 1;
         if (cols_reg > MAX_COLS_DEFAULT) return MAX_COLS_DEFAULT;
         return cols_reg;
      endfunction

      function int unsigned height_now();
         if (rows_reg < 1) return 1;
         if (rows_reg > MAX_ROWS_DEFAULT) return MAX_ROWS_DEFAULT;
         return rows_reg;
      endfunction

      function int pending();
         return due_reports.size();
      endfunction

      function logic [CELL_W-1:0] blank();
         return {bg, fg, 8'h00};
      endfunction

      function void poke(int unsigned idx, logic [CELL_W-1:0] v);
         if (idx < STORE_CELLS) cells[idx] = v;
      endfunction

      function logic [CELL_W-1:0] peek(int unsigned idx);
         return (idx < STORE_CELLS) ? cells[idx] : '0;
      endfunction

      function void clamp_cursor();
         if (cur_col >= width_now()) cur_col = width_now() - 1;
         if (cur_row >= height_now()) cur_row = height_now() - 1;
      endfunction

      function void shift_up(int unsigned n);
         int unsigned w, h, keep, i;
         w = width_now();
         h = height_now();
         if (n > h) n = h;
         if (n == 0) return;
         keep = (h - n) * w;
         for (i = 0; i < keep; i++) poke(i, peek(i + n * w));
         for (i = keep; i < h * w; i++) poke(i, blank());
      endfunction

      function void put_byte(logic [CHAR_W-1:0] c);
         int unsigned w, h, idx;
         w   = width_now();
         h   = height_now();
         idx = cur_col + cur_row * w;
         if (c == CH_NEWLINE) begin
            cur_row++;
            cur_col = 0;
         end else if (c == CH_TAB) begin
            poke(idx, blank());
            // second blank falls away past the end of the window
            if (idx + 1 < w * h) poke(idx + 1, blank());
            cur_col += 2;
         end else begin
            poke(idx, blank() | {8'h00, c});
            cur_col++;
         end
         if (cur_col >= w) begin
            cur_row++;
            cur_col = 0;
         end
         if (cur_row >= h) begin
            cur_row = h - 1;
            cur_col = 0;
            shift_up(1);
         end
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            REG_COLS: begin
               cols_reg = v;
               clamp_cursor();
            end
            REG_ROWS: begin
               rows_reg = v[ROW_W-1:0];
               clamp_cursor();
            end
            REG_FG: fg = v[COLOR_W-1:0];
            REG_BG: bg = v[COLOR_W-1:0];
            default: ;
         endcase
      endfunction

      // work out the report of one accepted request and queue it
      function void apply_action(req_payload_type p);
         rsp_payload_type   r;
         int unsigned       w, h, i, col, row;
         logic [CELL_W-1:0] cell_word;
         w = width_now();
         h = height_now();
         r = '0;
         case (p.action)
            ACT_PUT: put_byte(p.char_code);
            ACT_CLR_ALL: for (i = 0; i < w * h; i++) poke(i, blank());
            ACT_CLR_ROW: begin
               if (p.row_sel < h)
                  for (i = 0; i < w; i++) poke(p.row_sel * w + i, blank());
            end
            ACT_SCROLL: shift_up(p.scroll_count);
            ACT_SET_CUR: begin
               cur_col = (p.col_sel < w) ? p.col_sel : w - 1;
               cur_row = (p.row_sel < h) ? p.row_sel : h - 1;
            end
            ACT_READ: begin
               col       = (p.col_sel < w) ? p.col_sel : w - 1;
               row       = (p.row_sel < h) ? p.row_sel : h - 1;
               cell_word = peek(col + row * w);
               r.cell_char  = cell_word[7:0];
               r.cell_fg    = cell_word[11:8];
               r.cell_bg    = cell_word[15:12];
               r.shown_char = (cell_word[7:0] == 8'h00) ? CH_SPACE : cell_word[7:0];
            end
            default: ;
         endcase
         r.cursor_col = cur_col[COL_W-1:0];
         r.cursor_row = cur_row[ROW_W-1:0];
         due_reports.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      endtask

      task check_report(rsp_payload_type got);
         rsp_payload_type want;
         if (due_reports.size() == 0) begin
            report_mismatch("response transfer with no request outstanding");
         end else begin
            want = due_reports.pop_front();
            compare_field("cursor_col", 8'(got.cursor_col), 8'(want.cursor_col));
            compare_field("cursor_row", 8'(got.cursor_row), 8'(want.cursor_row));
            compare_field("cell_char", got.cell_char, want.cell_char);
            compare_field("cell_fg", 8'(got.cell_fg), 8'(want.cell_fg));
            compare_field("cell_bg", 8'(got.cell_bg), 8'(want.cell_bg));
            compare_field("shown_char", got.shown_char, want.shown_char);
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           idle_pct;
   char_window_scoreboard board;

   twce_req_if req_ch ();
   twce_rsp_if rsp_ch ();

   text_window_char_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         board.check_report(rsp_ch.payload);
   end

   function automatic req_payload_type pack_action(logic [ACTION_W-1:0] a,
                                                   logic [CHAR_W-1:0] c,
                                                   logic [ROW_W-1:0] r,
                                                   logic [COL_W-1:0] col,
                                                   logic [CNT_W-1:0] n);
      req_payload_type p;
      p.action       = a;
      p.char_code    = c;
      p.row_sel      = r;
      p.col_sel      = col;
      p.scroll_count = n;
      return p;
   endfunction

   // heavy store walks are kept rare in large windows
   function automatic req_payload_type random_action(int unsigned w, int unsigned h);
      req_payload_type p;
      int unsigned     roll, span;
      p = pack_action(ACTION_W'($urandom_range(7)), CHAR_W'($urandom_range(255)),
                      ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)),
                      CNT_W'($urandom_range(31)));
      span = (w * h > 400) ? 1 : 5;
      roll = $urandom_range(99);
      if (roll < 50) begin
         p.action = ACT_PUT;
      end else if (roll < 62) begin
         p.action = ACT_SET_CUR;
      end else if (roll < 82) begin
         p.action = ACT_READ;
      end else if (roll < 88) begin
         p.action = ACT_CLR_ROW;
      end else if (roll < 90) begin
         p.action = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
      end else if (roll < 90 + span) begin
         p.action = ACT_CLR_ALL;
      end else if (roll < 90 + 2 * span) begin
         p.action = ACT_SCROLL;
         if ($urandom_range(9) < 7) p.scroll_count = CNT_W'($urandom_range(h));
      end else begin
         p.action = ACT_PUT;
      end
      if (p.action == ACT_PUT) begin
         case ($urandom_range(9))
            0: p.char_code = CH_NEWLINE;
            1: p.char_code = CH_TAB;
            default: ;
         endcase
      end
      if ($urandom_range(9) < 7) begin
         p.col_sel = COL_W'($urandom_range(w - 1));
         p.row_sel = ROW_W'($urandom_range(h - 1));
      end
      return p;
   endfunction

   task automatic send_action(req_payload_type p);
      if ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= p;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.apply_action(p);
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic csr_put(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      board.write_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic load_settings(logic [CSR_DATA_W-1:0] c, logic [CSR_DATA_W-1:0] r,
                                logic [CSR_DATA_W-1:0] f, logic [CSR_DATA_W-1:0] b);
      hold_until_drained();
      csr_put(REG_COLS, c);
      csr_put(REG_ROWS, r);
      csr_put(REG_FG, f);
      csr_put(REG_BG, b);
      csr_we <= 1'b0;
   endtask

   initial begin
      #120ms;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int unsigned          phase, k;
      logic [CSR_DATA_W-1:0] set_cols, set_rows, set_fg, set_bg;
      board    = new();
      idle_pct = 20;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_addr       <= '0;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full-window clear first, so no cell is ever read before it is written
      send_action(pack_action(ACT_CLR_ALL, 8'h00, 5'd0, 7'd0, 5'd0));
      send_action(pack_action(ACT_READ, 8'h00, 5'd0, 7'd0, 5'd0));
      send_action(pack_action(ACT_PUT, 8'h41, 5'd0, 7'd0, 5'd0));
      send_action(pack_action(ACT_PUT, 8'hff, 5'd31, 7'd127, 5'd31));
      send_action(pack_action(ACT_PUT, 8'h00, 5'd0, 7'd0, 5'd0));
      send_action(pack_action(ACT_PUT, CH_TAB, 5'd0, 7'd0, 5'd0));
      send_action(pack_action(ACT_PUT, CH_NEWLINE, 5'd0, 7'd0, 5'd0));
      send_action(pack_action(ACT_READ, 8'h00, 5'd0, 7'd1, 5'd0));
      send_action(pack_action(ACT_READ, 8'h00, 5'd0, 7'd2, 5'd0));
      // last cell: write wraps off the bottom and scrolls
      send_action(pack_action(ACT_SET_CUR, 8'h00, 5'd24, 7'd79, 5'd0));
      send_action(pack_action(ACT_PUT, 8'h7e, 5'd0, 7'd0, 5'd0));
      send_action(pack_action(ACT_READ, 8'h00, 5'd23, 7'd79, 5'd0));
      // clamped cursor, then a tab whose second blank lies past the store end
      send_action(pack_action(ACT_SET_CUR, 8'h00, 5'd31, 7'd127, 5'd0));
      send_action(pack_action(ACT_PUT, CH_TAB, 5'd0, 7'd0, 5'd0));
      send_action(pack_action(ACT_READ, 8'h00, 5'd31, 7'd127, 5'd0));
      send_action(pack_action(ACT_SET_CUR, 8'h00, 5'd24, 7'd10, 5'd0));
      send_action(pack_action(ACT_PUT, CH_NEWLINE, 5'd0, 7'd0, 5'd0));
      send_action(pack_action(ACT_CLR_ROW, 8'h00, 5'd3, 7'd0, 5'd0));
      send_action(pack_action(ACT_CLR_ROW, 8'h00, 5'd25, 7'd0, 5'd0));
      send_action(pack_action(ACT_CLR_ROW, 8'h00, 5'd31, 7'd0, 5'd0));
      send_action(pack_action(ACT_SCROLL, 8'h00, 5'd0, 7'd0, 5'd0));
      send_action(pack_action(ACT_SCROLL, 8'h00, 5'd0, 7'd0, 5'd1));
      send_action(pack_action(ACT_SCROLL, 8'h00, 5'd0, 7'd0, 5'd31));
      send_action(pack_action(ACT_SPARE_LO, 8'h00, 5'd0, 7'd0, 5'd0));
      send_action(pack_action(ACT_SPARE_HI, 8'hff, 5'd31, 7'd127, 5'd31));

      for (phase = 0; phase < PHASES; phase++) begin
         set_fg = CSR_DATA_W'($urandom_range(127));
         set_bg = CSR_DATA_W'($urandom_range(127));
         case (phase)
            0: begin
               set_cols = CSR_DATA_W'($urandom_range(1, 12));
               set_rows = CSR_DATA_W'($urandom_range(1, 6));
            end
            1: begin
               set_cols = 7'd0;
               set_rows = 7'd0;
               set_fg   = 7'd0;
               set_bg   = 7'h7f;
            end
            2: begin
               set_cols = 7'h7f;
               set_rows = 7'h1f;
               set_fg   = 7'h7f;
               set_bg   = 7'd0;
            end
            3: begin
               set_cols = 7'd1;
               set_rows = 7'd25;
            end
            4: begin
               set_cols = 7'd80;
               set_rows = 7'd1;
            end
            5: begin
               set_cols = CSR_DATA_W'($urandom_range(1, 20));
               set_rows = CSR_DATA_W'($urandom_range(1, 10));
            end
            6: begin
               set_cols = CSR_DATA_W'($urandom_range(127));
               set_rows = CSR_DATA_W'($urandom_range(127));
            end
            7: begin
               set_cols = 7'd8;
               set_rows = 7'd4;
            end
            8: begin
               set_cols = 7'd3;
               set_rows = 7'd7;
            end
            default: begin
               set_cols = CSR_DATA_W'($urandom_range(1, 16));
               set_rows = CSR_DATA_W'($urandom_range(1, 8));
            end
         endcase
         load_settings(set_cols, set_rows, set_fg, set_bg);
         // one phase runs with both sides streaming flat out
         idle_pct = (phase == 5) ? 0 : 20;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2 && phase % 3 == 0) hold_until_drained();
            send_action(random_action(board.width_now(), board.height_now()));
         end
      end

      hold_until_drained();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### files.f
design/twce_pkg.sv
design/twce_if.sv
design/text_window_char_engine.sv
design/twce_checker.sv
bench/text_window_char_engine_test.sv
